// ===== design/spt_pkg.sv =====
// Shared types and constants for the scheduled pump timer.
`timescale 1ns / 1ps

package spt_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    KIND_SEC_TICK  = 2'd0,
    KIND_FAST_TICK = 2'd1,
    KIND_SET_TIME  = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  // Configuration register indexes. Slot words take indexes 0 to 3.
  localparam logic [2:0] CFG_SLOT_LAST  = 3'd3;
  localparam logic [2:0] CFG_SLOT_COUNT = 3'd4;
  localparam logic [2:0] CFG_FAST_TICKS = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int SLOT_WORD_W = 27;
  localparam int SLOT_IDX_W  = 2;
  localparam int SOD_W       = 17;
  localparam int TICKS_W     = 26;

  // Reset values of the configuration registers.
  localparam logic [SLOT_WORD_W-1:0] SLOT0_RESET      = 27'd29360248;
  localparam logic [SLOT_WORD_W-1:0] SLOT1_RESET      = 27'd71303228;
  localparam logic [2:0]             SLOT_COUNT_RESET = 3'd2;
  localparam logic [9:0]             FAST_TICKS_RESET = 10'd250;

  // Time-of-day limits.
  localparam logic [SOD_W-1:0] DAY_LAST      = 17'd86399;
  localparam logic [SOD_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [SOD_W-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [4:0]       HOUR_MAX      = 5'd23;
  localparam logic [5:0]       MINUTE_MAX    = 6'd59;

  // Command from the scheduler to the time-of-day counter.
  typedef struct packed {
    logic       tick;
    logic       load;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_cmd_t;

  // Reset value of a slot word by its index.
  function automatic logic [SLOT_WORD_W-1:0] slot_reset(input int idx);
    logic [SLOT_WORD_W-1:0] val;
    val = '0;
    if (idx == 0) val = SLOT0_RESET;
    if (idx == 1) val = SLOT1_RESET;
    return val;
  endfunction

endpackage

// ===== design/scheduled_pump_timer_top.sv =====
// Top level of the scheduled pump timer: handshake, schedule slots and pump control.
//
//   Channel  Signals                                          Direction
//   in       in_valid, in_ready, kind, new_hours, new_minutes,  into block
//            new_seconds
//   out      out_valid, out_ready, hours, minutes, seconds,    out of block
//            pump_on, active_slot
//   cfg      cfg_wr_en, cfg_index, cfg_data                   into block
//
// An item is taken into an input register and from there updates the state, whose
// registers show the result; one item per cycle while the result is taken.
// The state registers are the result register, so a stalled result holds while
// the input register takes one more item. After reset the pump is off, the time
// is 00:00:00 and slot 0 is awaited; no clearing pass is needed.
`timescale 1ns / 1ps

module scheduled_pump_timer_top
  import spt_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic [4:0]             new_hours,
  input  logic [5:0]             new_minutes,
  input  logic [5:0]             new_seconds,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4:0]             hours,
  output logic [5:0]             minutes,
  output logic [5:0]             seconds,
  output logic                   pump_on,
  output logic [SLOT_IDX_W-1:0]  active_slot,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SLOT_WORD_W-1:0] cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Configuration registers.
  logic [SLOT_WORD_W-1:0] slot_words [SLOTS];
  logic [2:0]             slot_count;
  logic [9:0]             fast_ticks_per_unit;

  // Input register.
  logic       s1_valid;
  kind_t      s1_kind;
  logic [4:0] s1_hours;
  logic [5:0] s1_minutes;
  logic [5:0] s1_seconds;

  // Schedule state.
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [SLOT_IDX_W-1:0] slot_index_next;
  logic [TICKS_W-1:0]    remaining_ticks;
  logic [TICKS_W-1:0]    remaining_ticks_next;
  logic                  pump_active;
  logic                  pump_active_next;

  logic                   advance;
  logic                   step;
  time_cmd_t              time_cmd;
  logic [SOD_W-1:0]       sod_next;
  logic [SLOT_WORD_W-1:0] cur_word;
  logic [SOD_W-1:0]       start_sod;
  logic [TICKS_W-1:0]     run_ticks;
  logic [2:0]             used_slots;
  logic [2:0]             slot_inc;

  // Handshake: the result slot frees when empty or taken.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind    <= kind_t'(kind);
      s1_hours   <= new_hours;
      s1_minutes <= new_minutes;
      s1_seconds <= new_seconds;
    end
  end

  // Configuration writes; slot words beyond the built slots are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_words[i] <= slot_reset(i);
      slot_count          <= SLOT_COUNT_RESET;
      fast_ticks_per_unit <= FAST_TICKS_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index <= CFG_SLOT_LAST && 32'(cfg_index) < SLOTS) begin
        slot_words[cfg_index[IW-1:0]] <= cfg_data;
      end else if (cfg_index == CFG_SLOT_COUNT) begin
        slot_count <= cfg_data[2:0];
      end else if (cfg_index == CFG_FAST_TICKS) begin
        fast_ticks_per_unit <= cfg_data[9:0];
      end
    end
  end

  // Time-of-day command for this item.
  always_comb begin
    time_cmd.tick    = step && (s1_kind == KIND_SEC_TICK);
    time_cmd.load    = step && (s1_kind == KIND_SET_TIME);
    time_cmd.hours   = s1_hours;
    time_cmd.minutes = s1_minutes;
    time_cmd.seconds = s1_seconds;
  end

  spt_time_of_day u_time (
    .clk      (clk),
    .rst      (rst),
    .cmd      (time_cmd),
    .sod_next (sod_next),
    .hours    (hours),
    .minutes  (minutes),
    .seconds  (seconds)
  );

  // Awaited slot: its start second and its run length in fast ticks.
  always_comb begin
    cur_word   = slot_words[slot_index[IW-1:0]];
    start_sod  = SOD_W'(cur_word[26:22]) * SECS_PER_HOUR + SOD_W'(cur_word[21:16]) * SECS_PER_MIN;
    run_ticks  = TICKS_W'(cur_word[15:0]) * TICKS_W'(fast_ticks_per_unit);
    used_slots = (slot_count == 3'd0) ? 3'd1 :
                 (32'(slot_count) > SLOTS) ? 3'(SLOTS) : slot_count;
    slot_inc   = {1'b0, slot_index} + 3'd1;
  end

  // Pump control: start on a match while off, count down on fast ticks, then stop and await the next slot.
  always_comb begin
    slot_index_next      = slot_index;
    remaining_ticks_next = remaining_ticks;
    pump_active_next     = pump_active;
    if (step) begin
      case (s1_kind)
        KIND_SEC_TICK: begin
          if (!pump_active && sod_next == start_sod) begin
            pump_active_next     = 1'b1;
            remaining_ticks_next = run_ticks;
          end
        end
        KIND_FAST_TICK: begin
          if (pump_active) begin
            if (remaining_ticks <= TICKS_W'(1)) begin
              remaining_ticks_next = '0;
              pump_active_next     = 1'b0;
              slot_index_next      = (slot_inc >= used_slots) ? '0 : slot_inc[SLOT_IDX_W-1:0];
            end else begin
              remaining_ticks_next = remaining_ticks - TICKS_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index      <= '0;
      remaining_ticks <= '0;
      pump_active     <= 1'b0;
    end else begin
      slot_index      <= slot_index_next;
      remaining_ticks <= remaining_ticks_next;
      pump_active     <= pump_active_next;
    end
  end

  assign pump_on     = pump_active;
  assign active_slot = slot_index;

endmodule

// ===== design/spt_time_of_day.sv =====
// Time-of-day counter kept both as seconds of day and as hours, minutes, seconds.
`timescale 1ns / 1ps

module spt_time_of_day
  import spt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  time_cmd_t        cmd,
  output logic [SOD_W-1:0] sod_next,
  output logic [4:0]       hours,
  output logic [5:0]       minutes,
  output logic [5:0]       seconds
);

  logic [SOD_W-1:0] sod;
  logic [SOD_W-1:0] sod_tick;
  logic [SOD_W-1:0] sod_load;
  logic [4:0]       hours_next;
  logic [5:0]       minutes_next;
  logic [5:0]       seconds_next;
  logic [4:0]       hours_sat;
  logic [5:0]       minutes_sat;
  logic [5:0]       seconds_sat;

  // Saturate a loaded time to the last valid value of each field.
  always_comb begin
    hours_sat   = (cmd.hours > HOUR_MAX) ? HOUR_MAX : cmd.hours;
    minutes_sat = (cmd.minutes > MINUTE_MAX) ? MINUTE_MAX : cmd.minutes;
    seconds_sat = (cmd.seconds > MINUTE_MAX) ? MINUTE_MAX : cmd.seconds;
    sod_load    = SOD_W'(hours_sat) * SECS_PER_HOUR + SOD_W'(minutes_sat) * SECS_PER_MIN
                  + SOD_W'(seconds_sat);
    sod_tick    = (sod >= DAY_LAST) ? '0 : sod + SOD_W'(1);
  end

  // Next value: a tick advances both forms together, a load sets both.
  always_comb begin
    sod_next     = sod;
    hours_next   = hours;
    minutes_next = minutes;
    seconds_next = seconds;
    if (cmd.load) begin
      sod_next     = sod_load;
      hours_next   = hours_sat;
      minutes_next = minutes_sat;
      seconds_next = seconds_sat;
    end else if (cmd.tick) begin
      sod_next = sod_tick;
      if (seconds >= MINUTE_MAX) begin
        seconds_next = '0;
        if (minutes >= MINUTE_MAX) begin
          minutes_next = '0;
          hours_next   = (hours >= HOUR_MAX) ? '0 : hours + 5'd1;
        end else begin
          minutes_next = minutes + 6'd1;
        end
      end else begin
        seconds_next = seconds + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sod     <= '0;
      hours   <= '0;
      minutes <= '0;
      seconds <= '0;
    end else begin
      sod     <= sod_next;
      hours   <= hours_next;
      minutes <= minutes_next;
      seconds <= seconds_next;
    end
  end

endmodule
